@@ rtl/core/iplq_pkg.sv @@
// ----------------------------------------------------------------------------
// IR pulse learn quantizer package
// Shared widths, command and register codes, reset values and the table that
// maps a stored class code to its pulse width in microseconds.
// ----------------------------------------------------------------------------
package iplq_pkg;

	localparam int DefBufferDepth = 256;

	localparam int CmdW   = 2;
	localparam int StampW = 16;
	localparam int IndexW = 8;
	localparam int DataW  = 13;
	localparam int CountW = 9;
	localparam int TallyW = 8;
	localparam int CodeW  = 3;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	typedef logic [CmdW-1:0]  cmd_t;
	typedef logic [CodeW-1:0] code_t;
	typedef logic [DataW-1:0] data_t;

	localparam cmd_t CMD_EDGE     = 2'd0;
	localparam cmd_t CMD_OVERFLOW = 2'd1;
	localparam cmd_t CMD_ARM      = 2'd2;
	localparam cmd_t CMD_READ     = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_SHORT_LOW  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_HIGH = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MID_HIGH   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LONG_HIGH  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_IDLE_LIMIT = 3'd4;

	localparam logic [StampW-1:0] RST_SHORT_LOW  = 16'd400;
	localparam logic [StampW-1:0] RST_SHORT_HIGH = 16'd700;
	localparam logic [StampW-1:0] RST_MID_HIGH   = 16'd2000;
	localparam logic [StampW-1:0] RST_LONG_HIGH  = 16'd3500;
	localparam logic [TallyW-1:0] RST_IDLE_LIMIT = 8'd2;

	localparam code_t CODE_NONE  = 3'd0;
	localparam code_t CODE_SHORT = 3'd1;
	localparam code_t CODE_MID   = 3'd2;
	localparam code_t CODE_LONG  = 3'd3;
	localparam code_t CODE_XLONG = 3'd4;

	function automatic data_t class_value(input code_t code);
		data_t v;
		unique case (code)
			CODE_SHORT: v = 13'd560;
			CODE_MID:   v = 13'd1680;
			CODE_LONG:  v = 13'd3000;
			CODE_XLONG: v = 13'd4500;
			default:    v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/iplq_if.sv @@
// ----------------------------------------------------------------------------
// IR pulse learn quantizer channels
// Request channel into the block and result channel out of it, each with a
// valid and ready handshake.
// ----------------------------------------------------------------------------
interface iplq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] capture_stamp;
	logic [7:0]  read_index;

	modport source (output valid, cmd, capture_stamp, read_index, input ready);
	modport sink   (input valid, cmd, capture_stamp, read_index, output ready);
endinterface

interface iplq_rsp_if;
	logic        valid;
	logic        ready;
	logic [12:0] data_value;
	logic        stored_now;
	logic [8:0]  entry_count;
	logic        capture_done;
	logic        falling_next;

	modport source (output valid, data_value, stored_now, entry_count, capture_done,
		falling_next, input ready);
	modport sink   (input valid, data_value, stored_now, entry_count, capture_done,
		falling_next, output ready);
endinterface

@@ rtl/core/ir_pulse_learn_quantizer_unit.sv @@
// ----------------------------------------------------------------------------
// IR pulse learn quantizer
// Learning receiver for infrared remotes: measures the time between edges,
// sorts each width into one of five classes and keeps the class codes.
// ----------------------------------------------------------------------------
// Usage: each request on req carries a command (edge capture, timer overflow
// tick, arm, read entry), a timer stamp and a read index. Every request gives
// exactly one result on rsp with the quantized width, a stored flag, the
// entry count, the done flag and the expected edge polarity.
// The control state updates in the cycle a request is accepted; the class
// codes live in a synchronous memory, so a result appears the cycle after
// its request. One request is accepted every cycle unless rsp stalls; the
// memory port sets the throughput with one write and one read per cycle.
// When rsp stalls, the result register holds and req stays ready only while
// the result register is empty or drains in the same cycle.
// Reset clears the control state, sets the expected polarity to falling and
// loads the threshold registers with their defaults. The class code memory
// is not cleared; entries at or above the entry count read back as zero.
// The cfg port writes thresholds and the idle overflow limit, one per cycle.
// ----------------------------------------------------------------------------
module ir_pulse_learn_quantizer_unit #(
	parameter int BUFFER_DEPTH = iplq_pkg::DefBufferDepth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [iplq_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [iplq_pkg::CfgDataW-1:0]     cfg_data,
	iplq_req_if.sink                          req,
	iplq_rsp_if.source                        rsp
);
	import iplq_pkg::*;

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int RW = (CW > IndexW) ? CW : IndexW;

	logic [StampW-1:0] short_low_q, short_high_q, mid_high_q, long_high_q;
	logic [TallyW-1:0] idle_limit_q;

	logic              armed_q, started_q, done_q, falling_q;
	logic [StampW-1:0] ref_stamp_q;
	logic [TallyW-1:0] tally_q;
	logic [CW-1:0]     count_q;

	logic              armed_d, started_d, done_d, falling_d;
	logic [StampW-1:0] ref_stamp_d;
	logic [TallyW-1:0] tally_d, tally_inc;
	logic [CW-1:0]     count_d;

	logic              accept;
	logic [StampW:0]   diff;
	logic [StampW-1:0] width;
	code_t             code;
	logic              wr_en, rd_en, rd_ok;
	logic [AW-1:0]     wr_addr, rd_addr;
	data_t             data_d;
	logic              stored_d;

	code_t             store_mem [BUFFER_DEPTH];

	logic              valid_s1, is_read_s1, rd_ok_s1, stored_s1, done_s1, falling_s1;
	data_t             data_s1;
	code_t             rd_code_s1;
	logic [CountW-1:0] count_s1;

	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || rsp.ready;

	// Width since the reference edge. With one counted overflow and the stamp
	// below the reference the width still fits in 16 bits; otherwise any
	// overflow pushes it past the top and it saturates.
	always_comb begin
		diff = {1'b0, req.capture_stamp} - {1'b0, ref_stamp_q};
		if (tally_q == '0 || (tally_q == TallyW'(1) && diff[StampW])) begin
			width = diff[StampW-1:0];
		end else begin
			width = '1;
		end
		priority if (width >= short_low_q && width <= short_high_q) begin
			code = CODE_SHORT;
		end else if (width > short_high_q && width <= mid_high_q) begin
			code = CODE_MID;
		end else if (width > mid_high_q && width <= long_high_q) begin
			code = CODE_LONG;
		end else if (width > long_high_q) begin
			code = CODE_XLONG;
		end else begin
			code = CODE_NONE;
		end
	end

	assign tally_inc = (tally_q == '1) ? tally_q : tally_q + TallyW'(1);
	assign wr_addr   = AW'(count_q);
	assign rd_addr   = AW'(req.read_index);
	assign rd_ok     = RW'(req.read_index) < RW'(count_q);

	always_comb begin
		armed_d     = armed_q;
		started_d   = started_q;
		done_d      = done_q;
		falling_d   = falling_q;
		ref_stamp_d = ref_stamp_q;
		tally_d     = tally_q;
		count_d     = count_q;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		data_d      = '0;
		stored_d    = 1'b0;
		if (accept) begin
			unique case (req.cmd)
				CMD_EDGE: begin
					if (armed_q && !done_q) begin
						if (started_q && count_q < CW'(BUFFER_DEPTH)) begin
							wr_en    = 1'b1;
							count_d  = count_q + CW'(1);
							data_d   = class_value(code);
							stored_d = 1'b1;
						end
						started_d   = 1'b1;
						ref_stamp_d = req.capture_stamp;
						tally_d     = '0;
						falling_d   = !falling_q;
					end
				end
				CMD_OVERFLOW: begin
					tally_d = tally_inc;
					if (count_q != '0 && tally_inc > idle_limit_q) begin
						done_d    = 1'b1;
						falling_d = 1'b1;
					end
				end
				CMD_ARM: begin
					armed_d   = 1'b1;
					started_d = 1'b0;
					done_d    = 1'b0;
					count_d   = '0;
				end
				CMD_READ: begin
					rd_en = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_low_q  <= RST_SHORT_LOW;
			short_high_q <= RST_SHORT_HIGH;
			mid_high_q   <= RST_MID_HIGH;
			long_high_q  <= RST_LONG_HIGH;
			idle_limit_q <= RST_IDLE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_LOW:  short_low_q  <= cfg_data;
				REG_SHORT_HIGH: short_high_q <= cfg_data;
				REG_MID_HIGH:   mid_high_q   <= cfg_data;
				REG_LONG_HIGH:  long_high_q  <= cfg_data;
				REG_IDLE_LIMIT: idle_limit_q <= cfg_data[TallyW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			started_q   <= 1'b0;
			done_q      <= 1'b0;
			falling_q   <= 1'b1;
			ref_stamp_q <= '0;
			tally_q     <= '0;
			count_q     <= '0;
		end else begin
			armed_q     <= armed_d;
			started_q   <= started_d;
			done_q      <= done_d;
			falling_q   <= falling_d;
			ref_stamp_q <= ref_stamp_d;
			tally_q     <= tally_d;
			count_q     <= count_d;
		end
	end

	// Entries below the count were all written in earlier cycles, so a read
	// never collides with the write of the same cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= code;
		end
		if (rd_en) begin
			rd_code_s1 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1 <= (req.cmd == CMD_READ);
			rd_ok_s1   <= rd_ok;
			data_s1    <= data_d;
			stored_s1  <= stored_d;
			count_s1   <= CountW'(count_d);
			done_s1    <= done_d;
			falling_s1 <= falling_d;
		end
	end

	assign rsp.valid        = valid_s1;
	assign rsp.data_value   = is_read_s1 ? (rd_ok_s1 ? class_value(rd_code_s1) : '0) : data_s1;
	assign rsp.stored_now   = stored_s1;
	assign rsp.entry_count  = count_s1;
	assign rsp.capture_done = done_s1;
	assign rsp.falling_next = falling_s1;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUFFER_DEPTH))
		else $error("entry count beyond buffer depth");

	a_done_has_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> count_q != '0)
		else $error("capture done with an empty buffer");

	a_started_armed: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> armed_q)
		else $error("capture started without arming");

	a_arm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_ARM) |=> (count_q == '0 && !done_q && !started_q))
		else $error("arm request did not clear the capture");

endmodule

@@ tb/iplq_quantize_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR pulse learn quantizer result checker
// Watches the request, result and register write ports of the quantizer.
// It keeps its own copy of the capture state and thresholds, works out the
// result of each accepted request and compares it field by field with the
// results that the block returns, in order.
// ----------------------------------------------------------------------------
module iplq_quantize_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iplq_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [iplq_pkg::CfgDataW-1:0] cfg_data,
	iplq_req_if                           req,
	iplq_rsp_if                           rsp,
	output int                            errors,
	output int                            pending
);
	import iplq_pkg::*;

	localparam int Depth = DefBufferDepth;
	localparam data_t ClassUs [5] = '{13'd0, 13'd560, 13'd1680, 13'd3000, 13'd4500};

	typedef struct packed {
		logic [DataW-1:0]  data_value;
		logic              stored_now;
		logic [CountW-1:0] entry_count;
		logic              capture_done;
		logic              falling_next;
	} reply_t;

	logic [StampW-1:0] short_low;
	logic [StampW-1:0] short_high;
	logic [StampW-1:0] mid_high;
	logic [StampW-1:0] long_high;
	logic [TallyW-1:0] idle_limit;

	logic              armed;
	logic              started;
	logic              done_flag;
	logic              falling;
	logic [StampW-1:0] ref_stamp;
	logic [TallyW-1:0] tally;
	logic [CountW-1:0] count;
	code_t             pulse_codes [Depth];

	reply_t predicted_replies [$];
	reply_t want;

	function automatic code_t quantize_width(input logic [StampW-1:0] w);
		if (w >= short_low && w <= short_high)
			return CODE_SHORT;
		if (w > short_high && w <= mid_high)
			return CODE_MID;
		if (w > mid_high && w <= long_high)
			return CODE_LONG;
		if (w > long_high)
			return CODE_XLONG;
		return CODE_NONE;
	endfunction

	function automatic reply_t quantizer_step(input cmd_t op, input logic [StampW-1:0] stamp,
		input logic [IndexW-1:0] idx);
		reply_t r;
		logic [23:0] span;
		logic [StampW-1:0] w;
		code_t c;
		r = '0;
		case (op)
			CMD_EDGE: begin
				if (armed && !done_flag) begin
					if (!started) begin
						started = 1'b1;
					end else begin
						// The overflow tally extends the stamp above bit 15.
						if ({tally, stamp} >= {8'd0, ref_stamp}) begin
							span = {tally, stamp} - {8'd0, ref_stamp};
							w = (span > 24'd65535) ? 16'hFFFF : span[15:0];
						end else begin
							w = stamp - ref_stamp;
						end
						if (count < Depth) begin
							c = quantize_width(w);
							pulse_codes[count[7:0]] = c;
							count = count + 1'b1;
							r.data_value = ClassUs[c];
							r.stored_now = 1'b1;
						end
					end
					ref_stamp = stamp;
					tally = '0;
					falling = !falling;
				end
			end
			CMD_OVERFLOW: begin
				if (tally != 8'hFF)
					tally = tally + 1'b1;
				if (count != 0 && tally > idle_limit) begin
					done_flag = 1'b1;
					falling = 1'b1;
				end
			end
			CMD_ARM: begin
				armed = 1'b1;
				started = 1'b0;
				done_flag = 1'b0;
				count = '0;
			end
			default: begin
				if (idx < count)
					r.data_value = ClassUs[pulse_codes[idx]];
			end
		endcase
		r.entry_count = count;
		r.capture_done = done_flag;
		r.falling_next = falling;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_low = RST_SHORT_LOW;
			short_high = RST_SHORT_HIGH;
			mid_high = RST_MID_HIGH;
			long_high = RST_LONG_HIGH;
			idle_limit = RST_IDLE_LIMIT;
			armed = 1'b0;
			started = 1'b0;
			done_flag = 1'b0;
			falling = 1'b1;
			ref_stamp = '0;
			tally = '0;
			count = '0;
			predicted_replies.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SHORT_LOW:  short_low = cfg_data;
					REG_SHORT_HIGH: short_high = cfg_data;
					REG_MID_HIGH:   mid_high = cfg_data;
					REG_LONG_HIGH:  long_high = cfg_data;
					REG_IDLE_LIMIT: idle_limit = cfg_data[TallyW-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (predicted_replies.size() == 0) begin
					errors++;
					$display("%0t: result with no request outstanding, expected none, got %0d",
						$time, rsp.data_value);
				end else begin
					want = predicted_replies.pop_front();
					check_field("data_value", 16'(want.data_value), 16'(rsp.data_value));
					check_field("stored_now", 16'(want.stored_now), 16'(rsp.stored_now));
					check_field("entry_count", 16'(want.entry_count), 16'(rsp.entry_count));
					check_field("capture_done", 16'(want.capture_done), 16'(rsp.capture_done));
					check_field("falling_next", 16'(want.falling_next), 16'(rsp.falling_next));
				end
			end
			if (req.valid && req.ready)
				predicted_replies.push_back(quantizer_step(req.cmd, req.capture_stamp,
					req.read_index));
			pending = predicted_replies.size();
		end
	end

endmodule

@@ tb/ir_pulse_learn_quantizer_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR pulse learn quantizer testbench
// Drives capture sessions into the quantizer: arm, a reference edge, edges
// spaced at and around the class thresholds, overflow ticks that stretch
// widths or end the capture, reads of stored entries, and some noise. Runs
// through several threshold settings and idle patterns on both channels,
// with one long result stall. The checker beside the block compares results.
// ----------------------------------------------------------------------------
module ir_pulse_learn_quantizer_unit_tb;
	import iplq_pkg::*;

	localparam int PhaseItems    = 360;
	localparam int HoldOffCycles = 300;
	localparam int StallLimit    = 3000;
	localparam logic [StampW-1:0] DirectedGaps [8] = '{16'd400, 16'd700, 16'd701, 16'd2000,
		16'd2001, 16'd3500, 16'd3501, 16'd399};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int errors;
	int pending;
	int quiet_cycles;
	int requests_sent;
	int send_idle_pct;
	int stall_pct;
	bit hold_pending;

	logic [StampW-1:0] band_edges [4];
	logic [TallyW-1:0] tick_limit;
	logic [StampW-1:0] stamp_now;

	iplq_req_if req ();
	iplq_rsp_if rsp ();

	ir_pulse_learn_quantizer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	iplq_quantize_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_req(input cmd_t op, input logic [StampW-1:0] stamp,
		input logic [IndexW-1:0] idx);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < send_idle_pct)
				@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= op;
		req.capture_stamp <= stamp;
		req.read_index <= idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic send_edge(input logic [StampW-1:0] gap);
		stamp_now = stamp_now + gap;
		send_req(CMD_EDGE, stamp_now, IndexW'($urandom_range(255, 0)));
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_req(CMD_OVERFLOW, StampW'($urandom_range(65535, 0)),
				IndexW'($urandom_range(255, 0)));
	endtask

	task automatic send_read(input int hi);
		send_req(CMD_READ, StampW'($urandom_range(65535, 0)), IndexW'($urandom_range(hi, 0)));
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] lo, input logic [15:0] sh,
		input logic [15:0] mh, input logic [15:0] lh, input logic [7:0] lim);
		write_reg(REG_SHORT_LOW, lo);
		write_reg(REG_SHORT_HIGH, sh);
		write_reg(REG_MID_HIGH, mh);
		write_reg(REG_LONG_HIGH, lh);
		write_reg(REG_IDLE_LIMIT, {8'd0, lim});
		cfg_we <= 1'b0;
		band_edges = '{lo, sh, mh, lh};
		tick_limit = lim;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [StampW-1:0] pick_width();
		int w;
		int b;
		b = $urandom_range(3, 0);
		case ($urandom_range(3, 0))
			0: w = $urandom_range(65535, 0);
			1: w = $urandom_range(4500, 100);
			default: w = int'(band_edges[b]) + int'($urandom_range(2, 0)) - 1;
		endcase
		if (w < 0)
			w = 0;
		if (w > 65535)
			w = 65535;
		return w[15:0];
	endfunction

	task automatic run_capture(input int n_edges);
		int r;
		send_req(CMD_ARM, StampW'($urandom_range(65535, 0)), IndexW'($urandom_range(255, 0)));
		stamp_now = StampW'($urandom_range(65535, 0));
		send_edge(16'd0);
		for (int k = 0; k < n_edges; k++) begin
			r = $urandom_range(99, 0);
			if (r < 8) begin
				send_read($urandom_range(1, 0) ? 255 : (k < 255 ? k : 255));
			end else if (r < 12) begin
				send_req(cmd_t'($urandom_range(3, 0)), StampW'($urandom_range(65535, 0)),
					IndexW'($urandom_range(255, 0)));
			end else if (r < 28 && tick_limit != 0) begin
				send_ticks($urandom_range(tick_limit < 3 ? int'(tick_limit) : 3, 1));
			end
			send_edge(pick_width());
		end
		if ($urandom_range(99, 0) < 60 && tick_limit < 6) begin
			send_ticks(int'(tick_limit) + 1);
			send_edge(pick_width());
			send_ticks(1);
		end
		repeat ($urandom_range(4, 1))
			send_read($urandom_range(1, 0) ? 255 : (n_edges < 255 ? n_edges : 255));
	endtask

	task automatic run_phase(input logic [15:0] lo, input logic [15:0] sh,
		input logic [15:0] mh, input logic [15:0] lh, input logic [7:0] lim,
		input int s_idle, input int r_stall, input bit long_first, input bit with_hold);
		int start;
		int sess;
		drain();
		set_config(lo, sh, mh, lh, lim);
		send_idle_pct = s_idle;
		stall_pct = r_stall;
		start = requests_sent;
		sess = 0;
		while (requests_sent - start < PhaseItems) begin
			if (with_hold && sess == 2)
				hold_pending = 1'b1;
			run_capture((long_first && sess == 0) ? $urandom_range(290, 258)
				: $urandom_range(40, 1));
			sess++;
		end
	endtask

	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end else begin
				rsp.ready <= ($urandom_range(99, 0) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("ir_pulse_learn_quantizer_unit_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] b0, b1, b2, b3;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SHORT_LOW;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.cmd <= CMD_EDGE;
		req.capture_stamp <= '0;
		req.read_index <= '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_pending = 1'b0;
		requests_sent = 0;
		band_edges = '{RST_SHORT_LOW, RST_SHORT_HIGH, RST_MID_HIGH, RST_LONG_HIGH};
		tick_limit = RST_IDLE_LIMIT;
		stamp_now = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests before the first arm change nothing but the overflow tally.
		send_req(CMD_EDGE, 16'hFFFF, 8'hFF);
		send_ticks(1);
		send_read(0);
		send_req(CMD_ARM, '0, '0);
		stamp_now = '0;
		send_edge(16'd0);
		foreach (DirectedGaps[i])
			send_edge(DirectedGaps[i]);
		// A full-range gap makes the stamp fall below the reference.
		send_edge(16'hFFFF);
		// Two ticks stay within the limit, so the next width saturates.
		send_ticks(2);
		send_edge(16'd10);
		send_read(0);
		send_req(CMD_READ, '0, 8'd9);
		send_req(CMD_READ, '0, 8'hFF);
		send_ticks(3);
		send_edge(16'd5);
		send_ticks(1);

		run_phase(16'd400, 16'd700, 16'd2000, 16'd3500, 8'd2, 0, 0, 1'b0, 1'b1);
		run_phase(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 83, 0, 1'b1, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0, 83, 1'b0, 1'b0);
		run_phase(16'd3000, 16'd100, 16'd50, 16'd60000, 8'd1, 15, 15, 1'b1, 1'b0);
		b0 = 16'($urandom_range(1000, 0));
		b1 = b0 + 16'($urandom_range(1000, 0));
		b2 = b1 + 16'($urandom_range(1000, 0));
		b3 = b2 + 16'($urandom_range(1000, 0));
		run_phase(b0, b1, b2, b3, 8'($urandom_range(6, 1)), 0, 0, 1'b0, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("ir_pulse_learn_quantizer_unit_tb: PASS");
		else
			$display("ir_pulse_learn_quantizer_unit_tb: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/iplq_pkg.sv
rtl/core/iplq_if.sv
rtl/core/ir_pulse_learn_quantizer_unit.sv
tb/iplq_quantize_checker.sv
tb/ir_pulse_learn_quantizer_unit_tb.sv
